### design/ibd_pkg.sv
`default_nettype none
package ibd_pkg;

   // frame geometry limits
   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 128;
   localparam int MAX_WINDOW  = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ADDR_W  = ROW_W + COL_W;
   localparam int TBL_W   = 22;
   localparam int RSUM_W  = 15;
   localparam int WSUM_W  = 15;
   localparam int PIX_W   = 8;
   localparam int IDX_W   = 7;
   localparam int DIM_W   = 8;
   localparam int WIN_W   = 5;
   localparam int CSR_W   = 8;
   localparam int AREA_W  = 2 * WIN_W;
   localparam int NCH     = 4;
   localparam int DIV_STEPS = 8;
   localparam int STEP_W  = $clog2(DIV_STEPS);

   // gray weights and the reciprocal of 100 (exact for sums up to 25500)
   localparam logic [WSUM_W-1:0] GRAY_WR = 15'd30;
   localparam logic [WSUM_W-1:0] GRAY_WG = 15'd59;
   localparam logic [WSUM_W-1:0] GRAY_WB = 15'd11;
   localparam int RECIP_W    = 13;
   localparam logic [RECIP_W-1:0] GRAY_RECIP = 13'd5243;
   localparam int GRAY_SHIFT = 19;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_WINDOW_SIZE,
      CSR_STEP_SIZE
   } csr_index_type;

   // effective geometry after clamping
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [WIN_W-1:0] win;
      logic [WIN_W-1:0] step;
   } geom_type;

   // one classified pixel passed from front to back
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [WSUM_W-1:0] wsum;
      logic [PIX_W-1:0]  red;
      logic [PIX_W-1:0]  green;
      logic [PIX_W-1:0]  blue;
      logic              emit;
      logic              done;
      logic [IDX_W-1:0]  out_i;
      logic [IDX_W-1:0]  out_j;
   } item_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_WRITE,
      B_READ_B,
      B_READ_D,
      B_READ_E,
      B_DIVIDE,
      B_OUTPUT
   } back_state_type;

endpackage
`default_nettype wire

### design/ibd_ram.sv
`default_nettype none
module ibd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### design/ibd_front.sv
`default_nettype none
module ibd_front
   import ibd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire geom_type         geom,
   input  wire logic             accept,
   input  wire logic [PIX_W-1:0] red,
   input  wire logic [PIX_W-1:0] green,
   input  wire logic [PIX_W-1:0] blue,
   input  wire logic             frame_start,
   output      item_type         item
);

   localparam int E_W = DIM_W + 2;

   logic [ROW_W-1:0] prow_ff, prow_in;
   logic [COL_W-1:0] pcol_ff, pcol_in;
   logic             col_run_ff, col_run_in;
   logic [WIN_W-1:0] col_cnt_ff, col_cnt_in;
   logic [IDX_W-1:0] col_j_ff, col_j_in;
   logic             row_run_ff, row_run_in;
   logic [WIN_W-1:0] row_cnt_ff, row_cnt_in;
   logic [IDX_W-1:0] row_i_ff, row_i_in;

   logic [ROW_W-1:0] pr, r;
   logic [COL_W-1:0] pc, c;
   logic [E_W-1:0]   rt, r_e, c_e, w_e, h_e, win_e, st_e;
   logic             col_al, row_al, col_fit, row_fit, col_more, row_more;

   always_comb begin
      w_e   = E_W'(geom.width);
      h_e   = E_W'(geom.height);
      win_e = E_W'(geom.win);
      st_e  = E_W'(geom.step);

      // position of this pixel, wrapping past the frame edge
      pr = frame_start ? '0 : prow_ff;
      pc = frame_start ? '0 : pcol_ff;
      if (E_W'(pc) >= w_e) begin
         c  = '0;
         rt = E_W'(pr) + E_W'(1);
      end else begin
         c  = pc;
         rt = E_W'(pr);
      end
      r   = (rt >= h_e) ? '0 : rt[ROW_W-1:0];
      r_e = E_W'(r);
      c_e = E_W'(c);

      // next position
      if (c_e + E_W'(1) >= w_e) begin
         pcol_in = '0;
         prow_in = (r_e + E_W'(1) >= h_e) ? '0 : r + ROW_W'(1);
      end else begin
         pcol_in = c + COL_W'(1);
         prow_in = r;
      end

      // column phase within the step grid
      if (c == '0) begin
         col_run_in = (geom.win == WIN_W'(1));
         col_cnt_in = '0;
         col_j_in   = '0;
      end else if (!col_run_ff) begin
         col_run_in = (c_e + E_W'(1) == win_e);
         col_cnt_in = '0;
         col_j_in   = '0;
      end else begin
         col_run_in = 1'b1;
         if (col_cnt_ff + WIN_W'(1) == geom.step) begin
            col_cnt_in = '0;
            col_j_in   = col_j_ff + IDX_W'(1);
         end else begin
            col_cnt_in = col_cnt_ff + WIN_W'(1);
            col_j_in   = col_j_ff;
         end
      end

      // row phase, advanced on the first pixel of a row
      if (c != '0) begin
         row_run_in = row_run_ff;
         row_cnt_in = row_cnt_ff;
         row_i_in   = row_i_ff;
      end else if (r == '0) begin
         row_run_in = (geom.win == WIN_W'(1));
         row_cnt_in = '0;
         row_i_in   = '0;
      end else if (!row_run_ff) begin
         row_run_in = (r_e + E_W'(1) == win_e);
         row_cnt_in = '0;
         row_i_in   = '0;
      end else begin
         row_run_in = 1'b1;
         if (row_cnt_ff + WIN_W'(1) == geom.step) begin
            row_cnt_in = '0;
            row_i_in   = row_i_ff + IDX_W'(1);
         end else begin
            row_cnt_in = row_cnt_ff + WIN_W'(1);
            row_i_in   = row_i_ff;
         end
      end

      col_al   = col_run_in && (col_cnt_in == '0);
      row_al   = row_run_in && (row_cnt_in == '0);
      // window fits inside the grid, and whether a further one follows
      col_fit  = (c_e + E_W'(1) + st_e <= w_e + win_e);
      row_fit  = (r_e + E_W'(1) + st_e <= h_e + win_e);
      col_more = (c_e + E_W'(1) + st_e + st_e <= w_e + win_e) &&
                 (c_e + E_W'(1) + st_e <= w_e);
      row_more = (r_e + E_W'(1) + st_e + st_e <= h_e + win_e) &&
                 (r_e + E_W'(1) + st_e <= h_e);

      item.row   = r;
      item.col   = c;
      item.wsum  = GRAY_WR * WSUM_W'(red) + GRAY_WG * WSUM_W'(green) +
                   GRAY_WB * WSUM_W'(blue);
      item.red   = red;
      item.green = green;
      item.blue  = blue;
      item.emit  = col_al && row_al && col_fit && row_fit;
      item.done  = !col_more && !row_more;
      item.out_i = row_i_in;
      item.out_j = col_j_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prow_ff    <= '0;
         pcol_ff    <= '0;
         col_run_ff <= 1'b0;
         col_cnt_ff <= '0;
         col_j_ff   <= '0;
         row_run_ff <= 1'b0;
         row_cnt_ff <= '0;
         row_i_ff   <= '0;
      end else if (accept) begin
         prow_ff    <= prow_in;
         pcol_ff    <= pcol_in;
         col_run_ff <= col_run_in;
         col_cnt_ff <= col_cnt_in;
         col_j_ff   <= col_j_in;
         row_run_ff <= row_run_in;
         row_cnt_ff <= row_cnt_in;
         row_i_ff   <= row_i_in;
      end
   end

endmodule
`default_nettype wire

### design/ibd_queue.sv
`default_nettype none
module ibd_queue
   import ibd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output      item_type head,
   output      logic     full,
   output      logic     not_empty
);

   localparam int PTR_W = $clog2(DEPTH);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign head      = mem_ff[rd_ptr_ff];
   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign not_empty = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // pointers wrap at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PTR_W+1)'(1);
         end
      end
   end

endmodule
`default_nettype wire

### design/ibd_back.sv
`default_nettype none
module ibd_back
   import ibd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [WIN_W-1:0]  win,
   input  wire logic [AREA_W-1:0] area,
   input  wire item_type          head,
   input  wire logic              head_valid,
   output      logic              pop,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [IDX_W-1:0]  rsp_out_row,
   output      logic [IDX_W-1:0]  rsp_out_col,
   output      logic [PIX_W-1:0]  rsp_avg_red,
   output      logic [PIX_W-1:0]  rsp_avg_green,
   output      logic [PIX_W-1:0]  rsp_avg_blue,
   output      logic [PIX_W-1:0]  rsp_avg_gray,
   output      logic              rsp_frame_done
);

   localparam int PROD_W = WSUM_W + RECIP_W;

   back_state_type state_ff, state_in;
   item_type       cur_ff;
   logic [RSUM_W-1:0] rs_ff  [NCH];
   logic [TBL_W-1:0]  a_ff   [NCH];
   logic [TBL_W-1:0]  b_ff   [NCH];
   logic [TBL_W-1:0]  d_ff   [NCH];
   logic [TBL_W-1:0]  rem_ff [NCH];
   logic [PIX_W-1:0]  quo_ff [NCH];
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;

   logic [PROD_W-1:0] gray_prod;
   logic [PIX_W-1:0]  px      [NCH];
   logic [RSUM_W-1:0] rs_new  [NCH];
   logic [TBL_W-1:0]  wr_data [NCH];
   logic [TBL_W-1:0]  rd_data [NCH];
   logic [TBL_W-1:0]  dvs;
   logic              wr_en, load_out, row_ok, col_ok;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [ROW_W-1:0]  row_b, row_up;
   logic [COL_W-1:0]  col_b;

   // table update values
   always_comb begin
      gray_prod = PROD_W'(cur_ff.wsum) * PROD_W'(GRAY_RECIP);
      px[0] = cur_ff.red;
      px[1] = cur_ff.green;
      px[2] = cur_ff.blue;
      px[3] = gray_prod[GRAY_SHIFT +: PIX_W];
      for (int ch = 0; ch < NCH; ch++) begin
         rs_new[ch]  = ((cur_ff.col == '0) ? '0 : rs_ff[ch]) + RSUM_W'(px[ch]);
         wr_data[ch] = ((cur_ff.row == '0) ? '0 : rd_data[ch]) + TBL_W'(rs_new[ch]);
      end
      row_ok = (ROW_W+1)'(cur_ff.row) >= (ROW_W+1)'(win);
      col_ok = (COL_W+1)'(cur_ff.col) >= (COL_W+1)'(win);
      row_b  = cur_ff.row - ROW_W'(win);
      col_b  = cur_ff.col - COL_W'(win);
      row_up = head.row - ROW_W'(1);
      dvs    = TBL_W'(area) << step_ff;
   end

   generate
      for (genvar g = 0; g < NCH; g++) begin : g_table
         ibd_ram #(
            .WIDTH (TBL_W),
            .DEPTH (1 << ADDR_W)
         ) u_ram (
            .clock   (clock),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data[g]),
            .rd_addr (rd_addr),
            .rd_data (rd_data[g])
         );
      end
   endgenerate

   // sequencer: next state, memory port control
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      wr_en    = 1'b0;
      load_out = 1'b0;
      wr_addr  = {cur_ff.row, cur_ff.col};
      rd_addr  = '0;
      unique case (state_ff)
         B_IDLE: begin
            rd_addr = {row_up, head.col};
            if (head_valid) begin
               pop      = 1'b1;
               state_in = B_WRITE;
            end
         end
         B_WRITE: begin
            wr_en    = 1'b1;
            rd_addr  = {row_b, cur_ff.col};
            state_in = cur_ff.emit ? B_READ_B : B_IDLE;
         end
         B_READ_B: begin
            rd_addr  = {cur_ff.row, col_b};
            state_in = B_READ_D;
         end
         B_READ_D: begin
            rd_addr  = {row_b, col_b};
            state_in = B_READ_E;
         end
         B_READ_E: begin
            state_in = B_DIVIDE;
         end
         B_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = B_OUTPUT;
            end
         end
         B_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // corner reads, difference and restoring division
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
      for (int ch = 0; ch < NCH; ch++) begin
         case (state_ff)
            B_WRITE: begin
               rs_ff[ch] <= rs_new[ch];
               a_ff[ch]  <= wr_data[ch];
            end
            B_READ_B: b_ff[ch] <= row_ok ? rd_data[ch] : '0;
            B_READ_D: d_ff[ch] <= col_ok ? rd_data[ch] : '0;
            B_READ_E: begin
               rem_ff[ch] <= a_ff[ch] - b_ff[ch] - d_ff[ch] +
                             ((row_ok && col_ok) ? rd_data[ch] : '0);
               quo_ff[ch] <= '0;
            end
            B_DIVIDE: begin
               if (rem_ff[ch] >= dvs) begin
                  rem_ff[ch]          <= rem_ff[ch] - dvs;
                  quo_ff[ch][step_ff] <= 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (state_ff == B_READ_E) begin
         step_ff <= STEP_W'(DIV_STEPS-1);
      end else if (state_ff == B_DIVIDE) begin
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_out_row    <= cur_ff.out_i;
         rsp_out_col    <= cur_ff.out_j;
         rsp_avg_red    <= quo_ff[0];
         rsp_avg_green  <= quo_ff[1];
         rsp_avg_blue   <= quo_ff[2];
         rsp_avg_gray   <= quo_ff[3];
         rsp_frame_done <= cur_ff.done;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### design/integral_image_box_downscale.sv
`default_nettype none
// channel   direction  handshake           word
// req_      in         req_valid/stall     red, green, blue, frame_start
// rsp_      out        rsp_valid/stall     out_row, out_col, avg_*, frame_done
// csr_      in         csr_wr_en           csr_index, csr_data
//
// A pixel passes the table stage through the idle and write states; a pixel that
// closes a window then also goes through three corner reads on the table port,
// eight quotient bits of the divider and one result load.
// The front accepts a pixel per cycle while the queue has room.
// Reset is synchronous; table contents are left unchanged by it.
// A stalled result holds in the output register while the front keeps going.
module integral_image_box_downscale
   import ibd_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic [PIX_W-1:0] req_red,
   input  wire logic [PIX_W-1:0] req_green,
   input  wire logic [PIX_W-1:0] req_blue,
   input  wire logic             req_frame_start,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic [IDX_W-1:0] rsp_out_row,
   output      logic [IDX_W-1:0] rsp_out_col,
   output      logic [PIX_W-1:0] rsp_avg_red,
   output      logic [PIX_W-1:0] rsp_avg_green,
   output      logic [PIX_W-1:0] rsp_avg_blue,
   output      logic [PIX_W-1:0] rsp_avg_gray,
   output      logic             rsp_frame_done,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_data
);

   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [WIN_W-1:0]  window_ff, step_ff;
   logic [AREA_W-1:0] area_ff;
   geom_type          geom;
   item_type          front_item, head;
   logic              accept, full, not_empty, pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(MAX_WIDTH);
         height_ff <= DIM_W'(MAX_HEIGHT);
         window_ff <= WIN_W'(1);
         step_ff   <= WIN_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: height_ff <= csr_data;
            CSR_WINDOW_SIZE:  window_ff <= csr_data[WIN_W-1:0];
            CSR_STEP_SIZE:    step_ff   <= csr_data[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped geometry
   always_comb begin
      geom.width  = (width_ff == '0) ? DIM_W'(1) :
                    (width_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
      geom.height = (height_ff == '0) ? DIM_W'(1) :
                    (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;
      geom.win    = (window_ff == '0) ? WIN_W'(1) :
                    (window_ff > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_ff;
      geom.step   = (step_ff == '0) ? WIN_W'(1) : step_ff;
   end

   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(geom.win) * AREA_W'(geom.win);
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   ibd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom),
      .accept      (accept),
      .red         (req_red),
      .green       (req_green),
      .blue        (req_blue),
      .frame_start (req_frame_start),
      .item        (front_item)
   );

   ibd_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .not_empty (not_empty)
   );

   ibd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .win            (geom.win),
      .area           (area_ff),
      .head           (head),
      .head_valid     (not_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_avg_red    (rsp_avg_red),
      .rsp_avg_green  (rsp_avg_green),
      .rsp_avg_blue   (rsp_avg_blue),
      .rsp_avg_gray   (rsp_avg_gray),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule
`default_nettype wire

### design/ibd_checker.sv
`default_nettype none
module ibd_checker
   import ibd_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [IDX_W-1:0] rsp_out_row,
   input wire logic [IDX_W-1:0] rsp_out_col,
   input wire logic [PIX_W-1:0] rsp_avg_red,
   input wire logic [PIX_W-1:0] rsp_avg_gray,
   input wire logic             rsp_frame_done
);

   // queue is empty after reset, so the input is open
   a_open_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("input stalled straight after reset");

   // no result word survives reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid straight after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_row) &&
      $stable(rsp_out_col) && $stable(rsp_avg_red) && $stable(rsp_avg_gray) &&
      $stable(rsp_frame_done))
      else $error("stalled result word changed");

   // stall only rises when words have been accepted into the queue
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("input stalled without an accepted word");

endmodule

bind integral_image_box_downscale ibd_checker u_checker (.*);
`default_nettype wire

### tb/sv/integral_image_box_downscale_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module integral_image_box_downscale_tb;
   import ibd_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_WAIT = 60;
   localparam int RANDOM_PIXELS = 40;

   // one downscaled pixel as seen on the result channel
   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] gray;
      logic             done;
   } box_word_type;

   // directed pixel, with the result typed in where it is obvious
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             frame_start;
      logic             typed;
      box_word_type     want;
   } pixel_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [PIX_W-1:0] req_red;
   logic [PIX_W-1:0] req_green;
   logic [PIX_W-1:0] req_blue;
   logic             req_frame_start;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [IDX_W-1:0] rsp_out_row;
   logic [IDX_W-1:0] rsp_out_col;
   logic [PIX_W-1:0] rsp_avg_red;
   logic [PIX_W-1:0] rsp_avg_green;
   logic [PIX_W-1:0] rsp_avg_blue;
   logic [PIX_W-1:0] rsp_avg_gray;
   logic             rsp_frame_done;
   logic             csr_wr_en;
   logic [1:0]       csr_index;
   logic [CSR_W-1:0] csr_data;

   integral_image_box_downscale u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_avg_red(rsp_avg_red), .rsp_avg_green(rsp_avg_green),
      .rsp_avg_blue(rsp_avg_blue), .rsp_avg_gray(rsp_avg_gray),
      .rsp_frame_done(rsp_frame_done),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block: registers, summed-area tables, row sums, position
   logic [7:0]        cfg_width, cfg_height;
   logic [4:0]        cfg_window, cfg_step;
   logic [TBL_W-1:0]  area_sums [NCH][MAX_WIDTH*MAX_HEIGHT];
   logic [RSUM_W-1:0] line_sums [NCH];
   int unsigned       next_row, next_col;
   box_word_type      pending_boxes [$];

   int  error_count = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;
   bit  rsp_take = 1'b0;
   bit  req_take = 1'b0;
   pixel_row_type directed_rows [10];

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // table update for one pixel, and the window average it closes if any
   task automatic predict_box(input logic [PIX_W-1:0] pr, pg, pb, input logic fs);
      int unsigned w, h, win, st, r, c, i, j, nr, nc, area, above, a, b, d, e, s;
      int unsigned px [NCH];
      int          ch;
      box_word_type res;
      w   = clamp_dim(cfg_width, MAX_WIDTH);
      h   = clamp_dim(cfg_height, MAX_HEIGHT);
      win = clamp_dim(cfg_window, MAX_WINDOW);
      st  = (cfg_step == 0) ? 1 : cfg_step;
      px[0] = pr;
      px[1] = pg;
      px[2] = pb;
      px[3] = (30 * pr + 59 * pg + 11 * pb) / 100;
      if (fs) begin
         next_row = 0;
         next_col = 0;
      end
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      r = next_row;
      c = next_col;
      for (ch = 0; ch < NCH; ch++) begin
         if (c == 0) line_sums[ch] = '0;
         line_sums[ch] = RSUM_W'(line_sums[ch] + px[ch]);
         above = (r > 0) ? area_sums[ch][(r-1)*MAX_WIDTH + c] : 0;
         area_sums[ch][r*MAX_WIDTH + c] = TBL_W'(above + line_sums[ch]);
      end
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
      if (r + 1 < win || c + 1 < win) return;
      if ((r + 1 - win) % st != 0 || (c + 1 - win) % st != 0) return;
      i = (r + 1 - win) / st;
      j = (c + 1 - win) / st;
      nr = h / st;
      nc = w / st;
      if (i >= nr || j >= nc) return;
      if ((h - win) / st + 1 < nr) nr = (h - win) / st + 1;
      if ((w - win) / st + 1 < nc) nc = (w - win) / st + 1;
      area = win * win;
      res.row = IDX_W'(i);
      res.col = IDX_W'(j);
      for (ch = 0; ch < NCH; ch++) begin
         a = area_sums[ch][r*MAX_WIDTH + c];
         b = (r >= win) ? area_sums[ch][(r-win)*MAX_WIDTH + c] : 0;
         d = (c >= win) ? area_sums[ch][r*MAX_WIDTH + c - win] : 0;
         e = (r >= win && c >= win) ? area_sums[ch][(r-win)*MAX_WIDTH + c - win] : 0;
         s = (a - b - d + e) & 32'h3F_FFFF;
         case (ch)
            0: res.red   = PIX_W'(s / area);
            1: res.green = PIX_W'(s / area);
            2: res.blue  = PIX_W'(s / area);
            default: res.gray = PIX_W'(s / area);
         endcase
      end
      res.done = (i + 1 == nr && j + 1 == nc);
      pending_boxes.push_back(res);
   endtask

   // hand one pixel word over; valid stays up when the next follows at once
   task automatic send_pixel(input logic [PIX_W-1:0] pr, pg, pb, input logic fs);
      int unsigned gap;
      bit          stalled;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red         <= pr;
      req_green       <= pg;
      req_blue        <= pb;
      req_frame_start <= fs;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      predict_box(pr, pg, pb, fs);
   endtask

   function automatic logic [PIX_W-1:0] pick_level();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // registers change only with the block idle
   task automatic set_geometry(input logic [7:0] w, h, input logic [4:0] win, st);
      logic [CSR_W-1:0] vals [4];
      int               k;
      vals = '{w, h, CSR_W'(win), CSR_W'(st)};
      req_valid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      for (k = 0; k < 4; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(k);
         csr_data  <= vals[k];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cfg_width  = w;
      cfg_height = h;
      cfg_window = win;
      cfg_step   = st;
   endtask

   // a frame of random pixels, now and then cut short, overrun or restarted
   task automatic send_frame(output int unsigned sent);
      int unsigned total, restart_at, k;
      int unsigned w, h;
      w = clamp_dim(cfg_width, MAX_WIDTH);
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      total = w * h;
      restart_at = total + 1;
      case ($urandom_range(0, 15))
         0, 1: total = $urandom_range(1, total);
         2:    total = total + $urandom_range(1, total);
         3:    restart_at = $urandom_range(1, total);
         default: ;
      endcase
      for (k = 0; k < total; k++)
         send_pixel(pick_level(), pick_level(), pick_level(), k == 0 || k == restart_at);
      sent = total;
   endtask

   // result monitor: the word is taken at the next rising edge
   always @(negedge clock) begin
      box_word_type want;
      rsp_take = !reset && rsp_valid && !rsp_stall;
      req_take = !reset && req_valid && !req_stall;
      if (rsp_take) begin
         if (pending_boxes.size() == 0) begin
            $error("result word with nothing expected: row %0d col %0d",
                   rsp_out_row, rsp_out_col);
            error_count++;
         end else begin
            want = pending_boxes.pop_front();
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_out_row);
               error_count++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_out_col);
               error_count++;
            end
            if (rsp_avg_red !== want.red) begin
               $error("avg_red: expected %0d, got %0d", want.red, rsp_avg_red);
               error_count++;
            end
            if (rsp_avg_green !== want.green) begin
               $error("avg_green: expected %0d, got %0d", want.green, rsp_avg_green);
               error_count++;
            end
            if (rsp_avg_blue !== want.blue) begin
               $error("avg_blue: expected %0d, got %0d", want.blue, rsp_avg_blue);
               error_count++;
            end
            if (rsp_avg_gray !== want.gray) begin
               $error("avg_gray: expected %0d, got %0d", want.gray, rsp_avg_gray);
               error_count++;
            end
            if (rsp_frame_done !== want.done) begin
               $error("frame_done: expected %0d, got %0d", want.done, rsp_frame_done);
               error_count++;
            end
         end
      end
   end

   // result back-pressure and the watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_take) stall_left = calm ? 0 : $urandom_range(0, 4);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
         if (rsp_take || req_take || csr_wr_en) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("integral_image_box_downscale_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      int unsigned random_sent, sent, frames, f, k;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      req_frame_start = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_FRAME_WIDTH;
      csr_data        = '0;
      cfg_width  = 8'd128;
      cfg_height = 8'd128;
      cfg_window = 5'd1;
      cfg_step   = 5'd1;
      next_row = 0;
      next_col = 0;
      for (k = 0; k < NCH; k++) line_sums[k] = '0;
      // reset geometry: one-pixel windows, so each average is the pixel itself
      directed_rows = '{
         '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, '{7'd0, 7'd0, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
         '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, '{7'd0, 7'd1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0}},
         '{8'd255, 8'd0,   8'd0,   1'b0, 1'b1, '{7'd0, 7'd2, 8'd255, 8'd0,   8'd0,   8'd76,  1'b0}},
         '{8'd0,   8'd255, 8'd0,   1'b0, 1'b1, '{7'd0, 7'd3, 8'd0,   8'd255, 8'd0,   8'd150, 1'b0}},
         '{8'd0,   8'd0,   8'd255, 1'b0, 1'b1, '{7'd0, 7'd4, 8'd0,   8'd0,   8'd255, 8'd28,  1'b0}},
         '{8'd170, 8'd85,  8'd170, 1'b0, 1'b1, '{7'd0, 7'd5, 8'd170, 8'd85,  8'd170, 8'd119, 1'b0}},
         '{8'd85,  8'd170, 8'd85,  1'b0, 1'b1, '{7'd0, 7'd6, 8'd85,  8'd170, 8'd85,  8'd135, 1'b0}},
         '{8'd1,   8'd1,   8'd1,   1'b1, 1'b1, '{7'd0, 7'd0, 8'd1,   8'd1,   8'd1,   8'd1,   1'b0}},
         '{8'd7,   8'd200, 8'd90,  1'b0, 1'b0, '0},
         '{8'd254, 8'd3,   8'd128, 1'b0, 1'b0, '0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pixels
      for (k = 0; k < 10; k++) begin
         send_pixel(directed_rows[k].red, directed_rows[k].green,
                    directed_rows[k].blue, directed_rows[k].frame_start);
         if (directed_rows[k].typed) begin
            void'(pending_boxes.pop_back());
            pending_boxes.push_back(directed_rows[k].want);
         end
      end

      // geometry extremes, out-of-range values saturating
      set_geometry(8'd4, 8'd4, 5'd2, 5'd2);
      send_frame(sent);
      set_geometry(8'd0, 8'd0, 5'd0, 5'd0);
      for (k = 0; k < 3; k++) send_pixel(pick_level(), pick_level(), pick_level(), k == 0);
      set_geometry(8'd128, 8'd1, 5'd1, 5'd1);
      send_frame(sent);
      set_geometry(8'd1, 8'd128, 5'd1, 5'd16);
      send_frame(sent);
      set_geometry(8'd255, 8'd2, 5'd31, 5'd3);
      for (k = 0; k < 40; k++) send_pixel(pick_level(), pick_level(), pick_level(), k == 0);
      set_geometry(8'd16, 8'd16, 5'd16, 5'd16);
      send_frame(sent);
      set_geometry(8'd17, 8'd3, 5'd2, 5'd0);
      send_frame(sent);

      // random geometries, small frames mostly
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         calm = ($urandom_range(0, 3) == 0);
         set_geometry(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                      ($urandom_range(0, 5) == 0) ? 5'($urandom_range(1, 8))
                                                  : 5'($urandom_range(1, 3)),
                      5'($urandom_range(1, 4)));
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            send_frame(sent);
            random_sent += sent;
         end
      end

      // drain
      req_valid <= 1'b0;
      calm = 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("integral_image_box_downscale_tb: clean");
      end else begin
         $display("integral_image_box_downscale_tb: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
